### src/lswr_pkg.sv
// ----------------------------------------------------------------------------
// lswr_pkg
// shared types and codes for the bounded lifo stack with reverse
// ----------------------------------------------------------------------------
package lswr_pkg;

	// width of the capacity register and of the entry count field
	localparam int CAP_W = 7;

	// capacity after reset
	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	// request codes
	localparam logic [1:0] MODE_PUSH    = 2'd0;
	localparam logic [1:0] MODE_POP     = 2'd1;
	localparam logic [1:0] MODE_PEEK    = 2'd2;
	localparam logic [1:0] MODE_REVERSE = 2'd3;

	typedef logic [1:0] status_t;

	// response status codes
	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_FULL  = 2'd2;

	// word returned by a pop or peek on an empty stack
	localparam logic [31:0] VAL_EMPTY = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [31:0] value_in;
	} req_t;

	typedef struct packed {
		logic signed [31:0] value_out;
		status_t            status;
		logic               is_empty;
		logic               is_full;
		logic [CAP_W-1:0]   entries_held;
	} rsp_t;

endpackage

### src/lswr_store.sv
// ----------------------------------------------------------------------------
// lswr_store
// entry memory: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module lswr_store #(
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem_q [DEPTH];
	logic [31:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### src/lswr_ctrl.sv
// ----------------------------------------------------------------------------
// lswr_ctrl
// request sequencer: entry count, swap walk for reverse, response build
// ----------------------------------------------------------------------------
module lswr_ctrl #(
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	parameter int CW    = $clog2(DEPTH + 1),
	parameter int CMPW  = (CW > lswr_pkg::CAP_W) ? CW : lswr_pkg::CAP_W
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  lswr_pkg::req_t  in_data,
	output logic            in_stall,
	input  logic            slot_free,
	input  logic [CMPW-1:0] cap_eff,
	output logic            mem_we,
	output logic [AW-1:0]   mem_waddr,
	output logic [31:0]     mem_wdata,
	output logic [AW-1:0]   mem_raddr,
	input  logic [31:0]     mem_rdata,
	output lswr_pkg::rsp_t  rsp,
	output logic            rsp_load
);

	localparam int AW1 = AW + 1;
	localparam int EHW = lswr_pkg::CAP_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD   = 3'd1;
	localparam logic [2:0] S_RV_A = 3'd2;
	localparam logic [2:0] S_RV_B = 3'd3;
	localparam logic [2:0] S_RV_C = 3'd4;

	logic [2:0]    state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [AW-1:0] lo_q, lo_d;
	logic [AW-1:0] hi_q, hi_d;
	logic [31:0]   tmp_q, tmp_d;
	logic [CW-1:0] count_m1;
	logic          accept;
	logic          full_now;
	logic          more_pairs;

	function automatic lswr_pkg::rsp_t make_rsp(
		input logic [31:0]       val,
		input lswr_pkg::status_t st,
		input logic [CW-1:0]     cnt
	);
		lswr_pkg::rsp_t r;
		r.value_out    = $signed(val);
		r.status       = st;
		r.is_empty     = (cnt == '0);
		r.is_full      = (CMPW'(cnt) >= cap_eff);
		r.entries_held = EHW'(cnt);
		return r;
	endfunction

	assign in_stall   = !((state_q == S_IDLE) && slot_free);
	assign accept     = in_valid && !in_stall;
	assign count_m1   = count_q - CW'(1);
	assign full_now   = (CMPW'(count_q) >= cap_eff);
	// another pair left once lo and hi step inward
	assign more_pairs = (AW1'(lo_q) + AW1'(2)) < AW1'(hi_q);

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		lo_d      = lo_q;
		hi_d      = hi_q;
		tmp_d     = tmp_q;
		mem_we    = 1'b0;
		mem_waddr = lo_q;
		mem_wdata = mem_rdata;
		mem_raddr = AW'(count_m1);
		rsp_load  = 1'b0;
		rsp       = make_rsp('0, lswr_pkg::ST_OK, count_q);
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (in_data.mode)
						lswr_pkg::MODE_PUSH: begin
							rsp_load = 1'b1;
							if (full_now) begin
								rsp = make_rsp('0, lswr_pkg::ST_FULL, count_q);
							end else begin
								mem_we    = 1'b1;
								mem_waddr = AW'(count_q);
								mem_wdata = in_data.value_in;
								count_d   = count_q + CW'(1);
								rsp       = make_rsp('0, lswr_pkg::ST_OK, count_d);
							end
						end
						lswr_pkg::MODE_POP, lswr_pkg::MODE_PEEK: begin
							if (count_q == '0) begin
								rsp_load = 1'b1;
								rsp = make_rsp(lswr_pkg::VAL_EMPTY, lswr_pkg::ST_EMPTY,
									count_q);
							end else begin
								mem_raddr = AW'(count_m1);
								if (in_data.mode == lswr_pkg::MODE_POP) begin
									count_d = count_m1;
								end
								state_d = S_RD;
							end
						end
						lswr_pkg::MODE_REVERSE: begin
							if (count_q <= CW'(1)) begin
								rsp_load = 1'b1;
							end else begin
								mem_raddr = '0;
								lo_d      = '0;
								hi_d      = AW'(count_m1);
								state_d   = S_RV_A;
							end
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_RD: begin
				rsp      = make_rsp(mem_rdata, lswr_pkg::ST_OK, count_q);
				rsp_load = 1'b1;
				state_d  = S_IDLE;
			end
			S_RV_A: begin
				// low entry arrives, fetch the high one
				tmp_d     = mem_rdata;
				mem_raddr = hi_q;
				state_d   = S_RV_B;
			end
			S_RV_B: begin
				mem_we    = 1'b1;
				mem_waddr = lo_q;
				mem_wdata = mem_rdata;
				state_d   = S_RV_C;
			end
			S_RV_C: begin
				mem_we    = 1'b1;
				mem_waddr = hi_q;
				mem_wdata = tmp_q;
				if (more_pairs) begin
					mem_raddr = lo_q + AW'(1);
					lo_d      = lo_q + AW'(1);
					hi_d      = hi_q - AW'(1);
					state_d   = S_RV_A;
				end else begin
					rsp_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		lo_q  <= lo_d;
		hi_q  <= hi_d;
		tmp_q <= tmp_d;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count beyond depth");

	a_walk_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RV_A || state_q == S_RV_B || state_q == S_RV_C) |-> (lo_q < hi_q))
		else $error("reverse walk indices crossed");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_data.mode == lswr_pkg::MODE_POP && count_q != '0)
		|=> (count_q == $past(count_m1)))
		else $error("pop did not drop the count by one");

	a_read_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD) |-> !mem_we)
		else $error("store written during pop or peek read");

endmodule

### src/lifo_stack_with_reverse.sv
// ----------------------------------------------------------------------------
// lifo_stack_with_reverse
// bounded lifo stack of signed 32-bit words with push, pop, peek and reverse
// ----------------------------------------------------------------------------
// usage:
//   in_valid/in_stall/in_data carry one request (mode, value_in) per transfer;
//   out_valid/out_stall/out_data carry exactly one response per request.
//   cfg_valid/cfg_ready/cfg_data write the capacity register; write it only
//   while no request is outstanding. cfg_ready is always high.
// request handling:
//   push, empty pop/peek and short reverse: response registered from the
//   request transfer, next request taken the cycle after if the output register is free.
//   pop/peek with data: passes through state S_RD for the registered memory read.
//   reverse of n >= 2 entries: swaps floor(n/2) pairs, paced by the single
//   read and single write port of the entry memory (read low, read high,
//   write low, write high while reading the next low).
// stall: the response sits in the output register; no new request is taken
//   while that register is full and out_stall is high.
// reset: entry count clears to zero and capacity goes to its reset value;
//   the entry memory itself is not cleared.
// ----------------------------------------------------------------------------
module lifo_stack_with_reverse #(
	parameter int DEPTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  lswr_pkg::req_t               in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output lswr_pkg::rsp_t               out_data,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [lswr_pkg::CAP_W-1:0]   cfg_data
);

	// address width into the store, count width, and compare width
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > lswr_pkg::CAP_W) ? CW : lswr_pkg::CAP_W;

	logic [lswr_pkg::CAP_W-1:0] capacity_q;
	logic [CMPW-1:0]            cap_ext;
	logic [CMPW-1:0]            cap_eff;

	logic           out_valid_q;
	lswr_pkg::rsp_t out_data_q;
	logic           slot_free;

	logic           rsp_load;
	lswr_pkg::rsp_t rsp;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [31:0]   mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [31:0]   mem_rdata;

	// capacity register, every write transfer is taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= lswr_pkg::CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	// zero behaves as one, anything above the built depth as the depth
	assign cap_ext = CMPW'(capacity_q);

	always_comb begin
		if (capacity_q == '0) begin
			cap_eff = CMPW'(1);
		end else if (cap_ext > CMPW'(DEPTH)) begin
			cap_eff = CMPW'(DEPTH);
		end else begin
			cap_eff = cap_ext;
		end
	end

	// output register; free when empty or draining this cycle
	assign slot_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rsp_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			out_data_q <= rsp;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	lswr_ctrl #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.CW    (CW),
		.CMPW  (CMPW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_data   (in_data),
		.in_stall  (in_stall),
		.slot_free (slot_free),
		.cap_eff   (cap_eff),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.rsp       (rsp),
		.rsp_load  (rsp_load)
	);

	lswr_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// a response must never overwrite one still waiting to be taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |-> !(out_valid_q && out_stall))
		else $error("response loaded over a stalled response");

endmodule
